// ===== sv/ohr_pkg.sv =====
// Shared types and constants of the offline HCI H4 responder
`default_nettype none

package ohr_pkg;

  // reply queue geometry
  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned QA_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

  // packet store geometry
  localparam int unsigned PKT_DEPTH   = 256;
  localparam int unsigned PKT_AW      = $clog2(PKT_DEPTH);
  localparam int unsigned PF_W        = 9;

  // result field width
  localparam int unsigned PENDING_W   = 11;

  // H4 and HCI codes
  localparam logic [7:0]  H4_CMD           = 8'h01;
  localparam logic [7:0]  H4_EVT           = 8'h04;
  localparam logic [7:0]  EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [7:0]  EVT_VENDOR       = 8'hff;
  localparam logic [7:0]  ST_HW_FAILURE    = 8'h03;
  localparam logic [7:0]  CC_PARAM_LEN     = 8'h04;
  localparam logic [7:0]  CC_NUM_PKTS      = 8'h01;
  localparam logic [15:0] VENDOR_OPCODE    = 16'hfc00;
  localparam logic [7:0]  BCCMD_MIN_LEN    = 8'd11;
  localparam logic [7:0]  BCCMD_FIX_LO     = 8'h01;
  localparam logic [7:0]  BCCMD_FIX_HI     = 8'h00;
  localparam logic [7:0]  BCCMD_FIX_LO_IDX = 8'd9;
  localparam logic [7:0]  BCCMD_FIX_HI_IDX = 8'd10;
  localparam logic [PF_W-1:0] HDR_BYTES    = 9'd4;
  // command complete event is seven bytes, last index six
  localparam logic [PF_W-1:0] CC_LAST_IDX  = 9'd6;

  // input transaction
  typedef struct packed {
    logic       command;
    logic [7:0] write_byte;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [7:0]           read_byte;
    logic                 read_valid;
    logic [PENDING_W-1:0] pending_count;
    logic                 reply_dropped;
  } result_t;

  // classified operation
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  // back end status seen by the top level
  typedef struct packed {
    logic [QC_W-1:0] queue_fill;
    logic            busy;
  } back_status_t;

endpackage

`default_nettype wire

// ===== sv/ohr_ram.sv =====
// Generic single write port, single read port RAM with registered read
`default_nettype none

module ohr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ohr_front.sv =====
// Front end: accepts input transactions, classifies them and queues them
`default_nettype none

module ohr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ohr_pkg::item_t in_item_i,
  output logic               op_valid_o,
  output ohr_pkg::op_t       op_o,
  input  wire logic          op_pop_i
);

  ohr_pkg::op_t entry_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         push;
  logic         pop;
  ohr_pkg::op_t op_new;

  // classify the incoming transaction
  always_comb begin
    op_new.kind = in_item_i.command ? ohr_pkg::OP_READ : ohr_pkg::OP_WRITE;
    op_new.data = in_item_i.write_byte;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (count_q != 2'd0);
  assign pop        = op_pop_i && op_valid_o;
  assign op_o       = entry_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ohr_back.sv =====
// Back end: H4 packet parser, reply generator, reply queue and result register
`default_nettype none

module ohr_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 op_valid_i,
  input  wire ohr_pkg::op_t         op_i,
  output logic                      op_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ohr_pkg::result_t          out_o,
  output ohr_pkg::back_status_t     status_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [ohr_pkg::PF_W-1:0]     pfill_q, pfill_d;
  logic [15:0]                  opcode_q, opcode_d;
  logic [7:0]                   length_q, length_d;
  logic [ohr_pkg::QA_W-1:0]     head_q, head_d;
  logic [ohr_pkg::QA_W-1:0]     tail_q, tail_d;
  logic [ohr_pkg::QC_W-1:0]     qfill_q, qfill_d;
  logic [ohr_pkg::PF_W-1:0]     k_q, k_d;
  logic [ohr_pkg::PF_W-1:0]     last_k_q, last_k_d;
  logic                         vendor_q, vendor_d;
  logic                         lost_q, lost_d;
  logic [7:0]                   rbyte_q, rbyte_d;
  logic                         rvalid_q, rvalid_d;
  logic                         out_valid_q;
  ohr_pkg::result_t             out_q;

  // parser next values for a written byte
  logic [7:0]                   wbyte;
  logic [7:0]                   len_nx;
  logic [15:0]                  op_nx;
  logic [ohr_pkg::PF_W-1:0]     pfill_inc;
  logic                         pkt_done;
  logic                         vendor_nx;

  // memory ports
  logic                         pk_we, pk_re;
  logic [ohr_pkg::PKT_AW-1:0]   pk_waddr, pk_raddr;
  logic [7:0]                   pk_rdata;
  logic                         rq_we, rq_re;
  logic [7:0]                   rq_wdata, rq_rdata;

  // reply byte selection
  logic [7:0]                   emit_byte;
  logic [7:0]                   pay_idx;
  logic                         queue_full;
  logic                         out_free;

  assign wbyte     = op_i.data;
  assign len_nx    = (pfill_q == 9'd3) ? wbyte : length_q;
  assign pfill_inc = pfill_q + 9'd1;
  assign pkt_done  = (pfill_q != 9'd0) && (pfill_inc >= ohr_pkg::HDR_BYTES)
                     && (pfill_inc == ohr_pkg::HDR_BYTES + {1'b0, len_nx});
  assign vendor_nx = (op_nx == ohr_pkg::VENDOR_OPCODE) && (len_nx >= ohr_pkg::BCCMD_MIN_LEN);
  assign queue_full = (qfill_q >= ohr_pkg::QC_W'(ohr_pkg::QUEUE_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;

  // opcode gathering
  always_comb begin
    op_nx = opcode_q;
    if (pfill_q == 9'd1) begin
      op_nx = {8'h00, wbyte};
    end else if (pfill_q == 9'd2) begin
      op_nx = {wbyte, opcode_q[7:0]};
    end
  end

  // packet store: payload writes while parsing, reads while emitting
  assign pk_we    = (state_q == ST_IDLE) && op_valid_i && (op_i.kind == ohr_pkg::OP_WRITE)
                    && (pfill_q >= ohr_pkg::HDR_BYTES);
  assign pk_waddr = ohr_pkg::PKT_AW'(pfill_q - ohr_pkg::HDR_BYTES);
  assign pk_re    = (state_q == ST_EMIT);
  // prefetch for the next reply byte: index four echoes payload byte one
  assign pk_raddr = (k_q == 9'd3) ? ohr_pkg::PKT_AW'(1) : ohr_pkg::PKT_AW'(k_q - 9'd2);

  ohr_ram #(
    .WIDTH (8),
    .DEPTH (ohr_pkg::PKT_DEPTH)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i (pk_waddr),
    .wdata_i (wbyte),
    .re_i    (pk_re),
    .raddr_i (pk_raddr),
    .rdata_o (pk_rdata)
  );

  // reply byte for the current emit index
  always_comb begin
    pay_idx   = 8'(k_q - 9'd3);
    emit_byte = 8'h00;
    if (vendor_q) begin
      case (k_q)
        9'd0:    emit_byte = ohr_pkg::H4_EVT;
        9'd1:    emit_byte = ohr_pkg::EVT_VENDOR;
        9'd2:    emit_byte = length_q;
        9'd3:    emit_byte = ohr_pkg::EVT_VENDOR;
        9'd4:    emit_byte = pk_rdata + 8'd1;
        default: begin
          if (pay_idx == ohr_pkg::BCCMD_FIX_LO_IDX) begin
            emit_byte = ohr_pkg::BCCMD_FIX_LO;
          end else if (pay_idx == ohr_pkg::BCCMD_FIX_HI_IDX) begin
            emit_byte = ohr_pkg::BCCMD_FIX_HI;
          end else begin
            emit_byte = pk_rdata;
          end
        end
      endcase
    end else begin
      case (k_q)
        9'd0:    emit_byte = ohr_pkg::H4_EVT;
        9'd1:    emit_byte = ohr_pkg::EVT_CMD_COMPLETE;
        9'd2:    emit_byte = ohr_pkg::CC_PARAM_LEN;
        9'd3:    emit_byte = ohr_pkg::CC_NUM_PKTS;
        9'd4:    emit_byte = opcode_q[7:0];
        9'd5:    emit_byte = opcode_q[15:8];
        default: emit_byte = ohr_pkg::ST_HW_FAILURE;
      endcase
    end
  end

  // reply queue memory
  assign rq_we    = (state_q == ST_EMIT) && !queue_full;
  assign rq_wdata = emit_byte;
  assign rq_re    = (state_q == ST_IDLE) && op_valid_i && (op_i.kind == ohr_pkg::OP_READ)
                    && (qfill_q != '0);

  ohr_ram #(
    .WIDTH (8),
    .DEPTH (ohr_pkg::QUEUE_DEPTH)
  ) u_reply_ram (
    .clk_i   (clk_i),
    .we_i    (rq_we),
    .waddr_i (tail_q),
    .wdata_i (rq_wdata),
    .re_i    (rq_re),
    .raddr_i (head_q),
    .rdata_o (rq_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    pfill_d  = pfill_q;
    opcode_d = opcode_q;
    length_d = length_q;
    head_d   = head_q;
    tail_d   = tail_q;
    qfill_d  = qfill_q;
    k_d      = k_q;
    last_k_d = last_k_q;
    vendor_d = vendor_q;
    lost_d   = lost_q;
    rbyte_d  = rbyte_q;
    rvalid_d = rvalid_q;
    op_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          rbyte_d  = 8'h00;
          rvalid_d = 1'b0;
          lost_d   = 1'b0;
          k_d      = '0;
          if (op_i.kind == ohr_pkg::OP_READ) begin
            state_d = (qfill_q != '0) ? ST_READ : ST_DONE;
          end else if (pfill_q == 9'd0) begin
            // idle: wait for the command indicator
            pfill_d = (wbyte == ohr_pkg::H4_CMD) ? 9'd1 : 9'd0;
            state_d = ST_DONE;
          end else begin
            opcode_d = op_nx;
            length_d = len_nx;
            if (pkt_done) begin
              pfill_d  = '0;
              vendor_d = vendor_nx;
              last_k_d = vendor_nx ? ({1'b0, len_nx} + 9'd2) : ohr_pkg::CC_LAST_IDX;
              state_d  = ST_EMIT;
            end else begin
              pfill_d = pfill_inc;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_READ: begin
        rbyte_d  = rq_rdata;
        rvalid_d = 1'b1;
        head_d   = (head_q == ohr_pkg::QA_W'(ohr_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        qfill_d  = qfill_q - 1'b1;
        state_d  = ST_DONE;
      end
      ST_EMIT: begin
        // push one reply byte per cycle, drop it when the queue is full
        if (queue_full) begin
          lost_d = 1'b1;
        end else begin
          tail_d  = (tail_q == ohr_pkg::QA_W'(ohr_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          qfill_d = qfill_q + 1'b1;
        end
        k_d = k_q + 9'd1;
        if (k_q == last_k_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pfill_q  <= '0;
      opcode_q <= '0;
      length_q <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      qfill_q  <= '0;
      k_q      <= '0;
      last_k_q <= '0;
      vendor_q <= 1'b0;
      lost_q   <= 1'b0;
      rbyte_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pfill_q  <= pfill_d;
      opcode_q <= opcode_d;
      length_q <= length_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      qfill_q  <= qfill_d;
      k_q      <= k_d;
      last_k_q <= last_k_d;
      vendor_q <= vendor_d;
      lost_q   <= lost_d;
      rbyte_q  <= rbyte_d;
      rvalid_q <= rvalid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.read_byte     <= rbyte_q;
      out_q.read_valid    <= rvalid_q;
      out_q.pending_count <= ohr_pkg::PENDING_W'(qfill_q);
      out_q.reply_dropped <= lost_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_o               = out_q;
  assign status_o.queue_fill = qfill_q;
  assign status_o.busy       = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/offline_hci_h4_responder.sv =====
// Top level of the offline HCI H4 responder
//
// Stands in for an absent Bluetooth controller on an H4 byte stream. Each
// input transaction either writes one host byte or reads one reply byte, and
// gives exactly one result transaction. Input transactions land in a
// two-entry queue, so the input side keeps flowing while a result waits on
// the output register. The back end handles one transaction at a time: a
// read that pops a byte goes through a registered read of the reply
// memory, and a write that finishes a packet first emits its whole reply
// (7 bytes for Command Complete, length + 3 for a vendor event) into the
// reply memory, one byte per cycle on its single write port. Both memories
// start undefined and need no clearing pass after reset.
`default_nettype none

module offline_hci_h4_responder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ohr_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ohr_pkg::result_t      out_o
);

  logic                  op_valid;
  logic                  op_pop;
  ohr_pkg::op_t          op;
  ohr_pkg::back_status_t status;

  // accept and classify
  ohr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // parse, reply and answer
  ohr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .status_o    (status)
  );

  // queue count never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.queue_fill <= ohr_pkg::QC_W'(ohr_pkg::QUEUE_DEPTH))
    else $error("reply queue count above depth");

  // a popped byte leaves room in the queue and never reports a drop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.read_valid |->
      !out_o.reply_dropped &&
      (out_o.pending_count < ohr_pkg::PENDING_W'(ohr_pkg::QUEUE_DEPTH)))
    else $error("pop transaction with drop flag or full count");

  // no popped byte means a zero read byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.read_valid |-> out_o.read_byte == 8'h00)
    else $error("read byte set without a pop");

  // back end takes work only when the front end has some
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> op_valid && !status.busy)
    else $error("pop from empty front queue or while busy");

endmodule

`default_nettype wire

// ===== tb/offline_hci_h4_responder_checker.sv =====
// Channel monitor, result predictor and scoreboard for the offline HCI H4 responder
`timescale 1ns / 100ps
`default_nettype none

module offline_hci_h4_responder_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire ohr_pkg::item_t   in_item_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire ohr_pkg::result_t out_i,
  output int                    fail_count_o,
  output int                    awaited_count_o,
  output int                    checked_count_o,
  output int                    vendor_count_o,
  output int                    hw_fail_count_o,
  output int                    dropped_count_o,
  output int                    peak_pending_o
);

  // room for results in flight, well above what the block can hold
  localparam int unsigned AWAIT_DEPTH = 16;

  // predictor copy of the responder state
  logic [7:0]               pkt_store [ohr_pkg::PKT_DEPTH];
  int unsigned              pkt_fill;
  logic [15:0]              hdr_opcode;
  logic [7:0]               hdr_len;
  logic [7:0]               reply_mem [ohr_pkg::QUEUE_DEPTH];
  logic [ohr_pkg::QA_W-1:0] reply_head;
  logic [ohr_pkg::QA_W-1:0] reply_tail;
  int unsigned              reply_fill;

  // results predicted but not yet seen on the output channel
  ohr_pkg::result_t         awaited_mem [AWAIT_DEPTH];
  logic [3:0]               awaited_head;
  logic [3:0]               awaited_tail;
  int unsigned              awaited_fill;

  // one line per mismatch
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0d ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // push one reply byte, or flag it lost when the fifo is full
  function automatic void queue_reply(input logic [7:0] b, inout bit lost);
    if (reply_fill >= ohr_pkg::QUEUE_DEPTH) begin
      lost = 1'b1;
      return;
    end
    reply_mem[reply_tail] = b;
    reply_tail = (reply_tail == ohr_pkg::QA_W'(ohr_pkg::QUEUE_DEPTH - 1)) ? '0
                 : reply_tail + 1'b1;
    reply_fill++;
  endfunction

  // reply for a complete packet: vendor echo or hardware failure
  function automatic void build_reply(inout bit lost);
    int unsigned i;
    if (hdr_opcode == ohr_pkg::VENDOR_OPCODE && hdr_len >= ohr_pkg::BCCMD_MIN_LEN) begin
      vendor_count_o++;
      queue_reply(ohr_pkg::H4_EVT, lost);
      queue_reply(ohr_pkg::EVT_VENDOR, lost);
      queue_reply(hdr_len, lost);
      queue_reply(ohr_pkg::EVT_VENDOR, lost);
      queue_reply(pkt_store[1] + 8'd1, lost);
      for (i = 2; i < hdr_len; i++) begin
        if (i == ohr_pkg::BCCMD_FIX_LO_IDX)
          queue_reply(ohr_pkg::BCCMD_FIX_LO, lost);
        else if (i == ohr_pkg::BCCMD_FIX_HI_IDX)
          queue_reply(ohr_pkg::BCCMD_FIX_HI, lost);
        else
          queue_reply(pkt_store[8'(i)], lost);
      end
    end else begin
      hw_fail_count_o++;
      queue_reply(ohr_pkg::H4_EVT, lost);
      queue_reply(ohr_pkg::EVT_CMD_COMPLETE, lost);
      queue_reply(ohr_pkg::CC_PARAM_LEN, lost);
      queue_reply(ohr_pkg::CC_NUM_PKTS, lost);
      queue_reply(hdr_opcode[7:0], lost);
      queue_reply(hdr_opcode[15:8], lost);
      queue_reply(ohr_pkg::ST_HW_FAILURE, lost);
    end
  endfunction

  // packet framing of one host byte
  function automatic void take_host_byte(input logic [7:0] v, inout bit lost);
    if (pkt_fill == 0) begin
      if (v == ohr_pkg::H4_CMD)
        pkt_fill = 1;
      return;
    end
    case (pkt_fill)
      1:       hdr_opcode = {8'h00, v};
      2:       hdr_opcode[15:8] = v;
      3:       hdr_len = v;
      default: pkt_store[8'(pkt_fill - 4)] = v;
    endcase
    pkt_fill++;
    if (pkt_fill >= 4 && pkt_fill == 4 + hdr_len) begin
      build_reply(lost);
      pkt_fill = 0;
    end
  endfunction

  // expected result of one transaction
  function automatic ohr_pkg::result_t predict_result(input ohr_pkg::item_t it);
    ohr_pkg::result_t r;
    bit               lost;
    r    = '0;
    lost = 1'b0;
    if (it.command == ohr_pkg::OP_READ) begin
      if (reply_fill > 0) begin
        r.read_byte  = reply_mem[reply_head];
        r.read_valid = 1'b1;
        reply_head = (reply_head == ohr_pkg::QA_W'(ohr_pkg::QUEUE_DEPTH - 1)) ? '0
                     : reply_head + 1'b1;
        reply_fill--;
      end
    end else begin
      take_host_byte(it.write_byte, lost);
    end
    r.pending_count = ohr_pkg::PENDING_W'(reply_fill);
    r.reply_dropped = lost;
    return r;
  endfunction

  // compare results first, then predict the transaction taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ohr_pkg::result_t want;
    if (!rst_ni) begin
      pkt_fill     = 0;
      hdr_opcode   = '0;
      hdr_len      = '0;
      reply_head   = '0;
      reply_tail   = '0;
      reply_fill   = 0;
      awaited_head = '0;
      awaited_tail = '0;
      awaited_fill = 0;
      fail_count_o    = 0;
      checked_count_o = 0;
      vendor_count_o  = 0;
      hw_fail_count_o = 0;
      dropped_count_o = 0;
      peak_pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_fill == 0) begin
          report_mismatch("result with nothing awaited", int'(out_i), 0);
        end else begin
          want = awaited_mem[awaited_head];
          awaited_head = awaited_head + 4'd1;
          awaited_fill--;
          checked_count_o++;
          if (out_i.read_byte !== want.read_byte)
            report_mismatch("read_byte", int'(out_i.read_byte), int'(want.read_byte));
          if (out_i.read_valid !== want.read_valid)
            report_mismatch("read_valid", int'(out_i.read_valid), int'(want.read_valid));
          if (out_i.pending_count !== want.pending_count)
            report_mismatch("pending_count", int'(out_i.pending_count),
                            int'(want.pending_count));
          if (out_i.reply_dropped !== want.reply_dropped)
            report_mismatch("reply_dropped", int'(out_i.reply_dropped),
                            int'(want.reply_dropped));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_result(in_item_i);
        if (want.reply_dropped)
          dropped_count_o++;
        if (int'(reply_fill) > peak_pending_o)
          peak_pending_o = int'(reply_fill);
        if (awaited_fill >= AWAIT_DEPTH) begin
          report_mismatch("transactions in flight", int'(awaited_fill), int'(AWAIT_DEPTH));
        end else begin
          awaited_mem[awaited_tail] = want;
          awaited_tail = awaited_tail + 4'd1;
          awaited_fill++;
        end
      end
    end
    awaited_count_o = int'(awaited_fill);
  end

endmodule

`default_nettype wire

// ===== tb/offline_hci_h4_responder_tb.sv =====
// Stimulus, stall generation and verdict for the offline HCI H4 responder
`timescale 1ns / 100ps
`default_nettype none

module offline_hci_h4_responder_tb;

  localparam int LONG_HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES    = 300;
  localparam int MIX_ITEMS        = 300;
  localparam int FILL_PACKETS     = 160;
  localparam int DRAIN_READS      = 64;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  ohr_pkg::item_t   in_item_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  ohr_pkg::result_t out_o;

  int fail_count;
  int awaited_count;
  int checked_count;
  int vendor_count;
  int hw_fail_count;
  int dropped_count;
  int peak_pending;

  // random idling switches and the long output hold request
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  bit long_hold_req  = 1'b0;
  int items_sent     = 0;

  offline_hci_h4_responder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  offline_hci_h4_responder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_i           (out_o),
    .fail_count_o    (fail_count),
    .awaited_count_o (awaited_count),
    .checked_count_o (checked_count),
    .vendor_count_o  (vendor_count),
    .hw_fail_count_o (hw_fail_count),
    .dropped_count_o (dropped_count),
    .peak_pending_o  (peak_pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard limit on run length
  initial begin
    #2_000_000;
    $display("timed out with %0d results still awaited", awaited_count);
    $display("offline_hci_h4_responder_tb: FAIL");
    $finish;
  end

  // output stall: random short bursts, plus one long hold on request
  initial begin : stall_gen
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // offer one transaction and wait until it is taken
  task automatic offer(input ohr_pkg::op_kind_e kind, input logic [7:0] data);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{command: kind, write_byte: data};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // H4 command header, then part or all of a random payload
  task automatic send_packet(input logic [15:0] opcode, input int unsigned len,
                             input int unsigned sent_len);
    int unsigned i;
    offer(ohr_pkg::OP_WRITE, ohr_pkg::H4_CMD);
    offer(ohr_pkg::OP_WRITE, opcode[7:0]);
    offer(ohr_pkg::OP_WRITE, opcode[15:8]);
    offer(ohr_pkg::OP_WRITE, 8'(len));
    for (i = 0; i < sent_len; i++)
      offer(ohr_pkg::OP_WRITE, 8'($urandom));
    items_sent += 4 + sent_len;
  endtask

  task automatic send_reads(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++)
      offer(ohr_pkg::OP_READ, 8'($urandom));
    items_sent += n;
  endtask

  // idle bytes, mostly kept away from the command indicator
  task automatic send_noise(input int unsigned n);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (b == ohr_pkg::H4_CMD && $urandom_range(0, 7) != 0)
        b = 8'h02;
      offer(ohr_pkg::OP_WRITE, b);
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned len;
    int unsigned pick;
    bit          hold_done;
    bit          max_len_done;
    hold_done    = 1'b0;
    max_len_done = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty read, idle strays, zero-length command, minimal vendor command
    offer(ohr_pkg::OP_READ, 8'hff);
    offer(ohr_pkg::OP_WRITE, 8'h00);
    offer(ohr_pkg::OP_WRITE, 8'hff);
    offer(ohr_pkg::OP_WRITE, ohr_pkg::H4_CMD);
    offer(ohr_pkg::OP_WRITE, 8'hff);
    offer(ohr_pkg::OP_WRITE, 8'hff);
    offer(ohr_pkg::OP_WRITE, 8'h00);
    offer(ohr_pkg::OP_WRITE, ohr_pkg::H4_CMD);
    offer(ohr_pkg::OP_WRITE, ohr_pkg::VENDOR_OPCODE[7:0]);
    offer(ohr_pkg::OP_WRITE, ohr_pkg::VENDOR_OPCODE[15:8]);
    offer(ohr_pkg::OP_WRITE, ohr_pkg::BCCMD_MIN_LEN);
    // second payload byte 0xff wraps on increment, fixed low byte is sent as 0xff, fixed high byte as 0x00
    for (i = 0; i < ohr_pkg::BCCMD_MIN_LEN; i++)
      offer(ohr_pkg::OP_WRITE, (i == 1 || i[0]) ? 8'hff : 8'h00);
    send_reads(3);

    // random mix of packets, reads, noise and truncated payloads
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    while (items_sent < MIX_ITEMS) begin
      if (!hold_done && items_sent > 60) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (!max_len_done && items_sent > 120) begin
          len          = 255;
          max_len_done = 1'b1;
        end else begin
          len = $urandom_range(ohr_pkg::BCCMD_MIN_LEN, 40);
        end
        send_packet(ohr_pkg::VENDOR_OPCODE, len, len);
      end else if (pick < 55) begin
        len = $urandom_range(0, ohr_pkg::BCCMD_MIN_LEN - 1);
        send_packet(ohr_pkg::VENDOR_OPCODE, len, len);
      end else if (pick < 75) begin
        len = $urandom_range(0, 12);
        send_packet(16'($urandom), len, len);
      end else if (pick < 78) begin
        // header with a short payload, the next bytes finish it
        len = $urandom_range(2, 8);
        send_packet(16'($urandom), len, len / 2);
      end else if (pick < 88) begin
        send_noise($urandom_range(1, 6));
      end
      send_reads($urandom_range(0, 24));
    end

    // sender pause until every result is back
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (awaited_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // no idling from here on: overflow the reply queue, then read some back
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (i = 0; i < FILL_PACKETS; i++)
      send_packet(16'($urandom), 0, 0);
    send_reads(DRAIN_READS);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (awaited_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run checked %0d results: %0d vendor events, %0d hardware failure replies",
             checked_count, vendor_count, hw_fail_count);
    $display("reply queue peaked at %0d bytes, %0d writes lost reply bytes",
             peak_pending, dropped_count);
    if (fail_count == 0)
      $display("offline_hci_h4_responder_tb: PASS");
    else
      $display("offline_hci_h4_responder_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ohr_pkg.sv
sv/ohr_ram.sv
sv/ohr_front.sv
sv/ohr_back.sv
sv/offline_hci_h4_responder.sv
tb/offline_hci_h4_responder_checker.sv
tb/offline_hci_h4_responder_tb.sv
